FILE: sv/mpfm_pkg.sv
// shared types and constants for the multiport packet fifo merge
// no dependencies
`default_nettype none

package mpfm_pkg;

   localparam int MAX_PORTS = 4;
   localparam int PORT_W = 2;
   localparam int BUF_SIZE_W = 7;
   localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 7'd64;

   typedef logic [PORT_W-1:0] port_idx_type;

   // one push and one pop command for the queue store
   typedef struct packed {
      logic         push;
      port_idx_type push_port;
      logic         pop;
      port_idx_type pop_port;
   } mpfm_qcmd_type;

endpackage

`default_nettype wire

FILE: sv/mpfm_if.sv
// channel interfaces: input flits, result, buffer size write
// depends on mpfm_pkg
`default_nettype none

interface mpfm_req_if
   import mpfm_pkg::*;
#(
   parameter int FLIT_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [MAX_PORTS-1:0] arrive_mask;
   logic [MAX_PORTS-1:0] tail_mask;
   logic [FLIT_BITS-1:0] flit_port0;
   logic [FLIT_BITS-1:0] flit_port1;
   logic [FLIT_BITS-1:0] flit_port2;
   logic [FLIT_BITS-1:0] flit_port3;
   logic                 downstream_stop;

   modport source (
      output valid, arrive_mask, tail_mask, flit_port0, flit_port1, flit_port2,
             flit_port3, downstream_stop,
      input  ready
   );
   modport sink (
      input  valid, arrive_mask, tail_mask, flit_port0, flit_port1, flit_port2,
             flit_port3, downstream_stop,
      output ready
   );
endinterface

interface mpfm_rsp_if
   import mpfm_pkg::*;
#(
   parameter int FLIT_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic                 out_valid;
   logic [FLIT_BITS-1:0] out_flit;
   logic                 out_tail;
   port_idx_type         out_source;
   logic [MAX_PORTS-1:0] stop_mask;
   logic                 overflow;

   modport source (
      output valid, out_valid, out_flit, out_tail, out_source, stop_mask, overflow,
      input  ready
   );
   modport sink (
      input  valid, out_valid, out_flit, out_tail, out_source, stop_mask, overflow,
      output ready
   );
endinterface

interface mpfm_csr_if
   import mpfm_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [BUF_SIZE_W-1:0] buffer_size;

   modport source (output valid, buffer_size, input ready);
   modport sink (input valid, buffer_size, output ready);
endinterface

`default_nettype wire

FILE: sv/mpfm_queues.sv
// per-port ring queues sharing one synchronous flit memory, with free count
// depends on mpfm_pkg
`default_nettype none

module mpfm_queues
   import mpfm_pkg::*;
#(
   parameter int PORTS = 4,
   parameter int CAPACITY = 64,
   parameter int FLIT_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire mpfm_qcmd_type                           cmd,
   input  wire logic [FLIT_BITS:0]                      push_data,
   input  wire logic [BUF_SIZE_W-1:0]                   buffer_size,
   output logic [MAX_PORTS-1:0]                         nonempty,
   output logic [$clog2(CAPACITY+1)-1:0]                free_cnt,
   output logic [FLIT_BITS:0]                           pop_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = $clog2(CAPACITY);
   localparam int AW = $clog2(PORTS * CAPACITY);
   localparam int EW = (CW > BUF_SIZE_W) ? CW : BUF_SIZE_W;
   localparam int DW = FLIT_BITS + 1;
   localparam logic [PW-1:0] LAST_PTR = PW'(CAPACITY - 1);
   localparam logic [EW-1:0] CAP_EXT = EW'(CAPACITY);

   logic [DW-1:0] mem [PORTS*CAPACITY];
   logic [DW-1:0] pop_data_ff;

   logic [PW-1:0] head_ff [PORTS];
   logic [PW-1:0] head_in [PORTS];
   logic [PW-1:0] tail_ff [PORTS];
   logic [PW-1:0] tail_in [PORTS];
   logic [CW-1:0] count_ff [PORTS];
   logic [CW-1:0] count_in [PORTS];
   logic [CW-1:0] total_ff;
   logic [CW-1:0] total_in;

   logic [PW-1:0] push_ptr;
   logic [PW-1:0] pop_ptr;
   logic [AW-1:0] push_addr;
   logic [AW-1:0] pop_addr;
   logic [EW-1:0] size_ext;
   logic [CW-1:0] eff_size;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] ptr);
      if (ptr == LAST_PTR) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      push_ptr = '0;
      pop_ptr = '0;
      for (int p = 0; p < PORTS; p++) begin
         if (cmd.push_port == PORT_W'(p)) begin
            push_ptr = tail_ff[p];
         end
         if (cmd.pop_port == PORT_W'(p)) begin
            pop_ptr = head_ff[p];
         end
      end
   end

   assign push_addr = AW'(cmd.push_port) * AW'(CAPACITY) + AW'(push_ptr);
   assign pop_addr = AW'(cmd.pop_port) * AW'(CAPACITY) + AW'(pop_ptr);

   // effective size is the register clipped to the store capacity
   assign size_ext = EW'(buffer_size);
   assign eff_size = (size_ext > CAP_EXT) ? CW'(CAPACITY) : size_ext[CW-1:0];
   assign free_cnt = (eff_size > total_ff) ? (eff_size - total_ff) : '0;

   always_comb begin
      total_in = total_ff;
      if (cmd.push) begin
         total_in = total_in + 1'b1;
      end
      if (cmd.pop) begin
         total_in = total_in - 1'b1;
      end
      for (int p = 0; p < PORTS; p++) begin
         head_in[p] = head_ff[p];
         tail_in[p] = tail_ff[p];
         count_in[p] = count_ff[p];
         if (cmd.push && cmd.push_port == PORT_W'(p)) begin
            tail_in[p] = ring_next(tail_ff[p]);
            count_in[p] = count_in[p] + 1'b1;
         end
         if (cmd.pop && cmd.pop_port == PORT_W'(p)) begin
            head_in[p] = ring_next(head_ff[p]);
            count_in[p] = count_in[p] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int p = 0; p < PORTS; p++) begin
            head_ff[p] <= '0;
            tail_ff[p] <= '0;
            count_ff[p] <= '0;
         end
      end else begin
         total_ff <= total_in;
         for (int p = 0; p < PORTS; p++) begin
            head_ff[p] <= head_in[p];
            tail_ff[p] <= tail_in[p];
            count_ff[p] <= count_in[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[push_addr] <= push_data;
      end
      if (cmd.pop) begin
         pop_data_ff <= mem[pop_addr];
      end
   end

   assign pop_data = pop_data_ff;

   for (genvar gp = 0; gp < MAX_PORTS; gp++) begin : g_ne
      if (gp < PORTS) begin : g_real
         assign nonempty[gp] = |count_ff[gp];
      end else begin : g_absent
         assign nonempty[gp] = 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_push_has_room : assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> free_cnt != '0)
      else $error("push into a full buffer");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> nonempty[cmd.pop_port])
      else $error("pop from an empty queue");

   a_total_bound : assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      cmd.push && !cmd.pop |=> total_ff == $past(total_ff) + 1'b1)
      else $error("occupancy did not follow a push");
`endif

endmodule

`default_nettype wire

FILE: sv/multiport_packet_fifo_merge.sv
// multiport packet fifo merge: per-port queues in one shared flit memory,
// wormhole arbitration onto one output link
// transactions: a new one is accepted only in the idle state, after the last has finished;
//   arrivals are written one port per cycle through the single memory write port,
//   then a select state and a data state read the queue and produce the sent flit;
//   a held result stalls the data state
// reset: synchronous; queues empty, no packet locked, buffer size 64; the
//   flit memory is not cleared (entries are read only after being written)
`default_nettype none

module multiport_packet_fifo_merge
   import mpfm_pkg::*;
#(
   parameter int PORTS = 4,
   parameter int CAPACITY = 64,
   parameter int FLIT_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   mpfm_req_if.sink   req_ch,
   mpfm_rsp_if.source rsp_ch,
   mpfm_csr_if.sink   csr_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CMP_W = CW + 4;
   localparam logic [CMP_W-1:0] LIM_LOW = CMP_W'(PORTS + 1);
   localparam logic [CMP_W-1:0] LIM_HIGH = CMP_W'(2 * PORTS + 1);
   localparam logic [MAX_PORTS-1:0] PORT_ALL = MAX_PORTS'((1 << PORTS) - 1);
   localparam port_idx_type LAST_PORT = PORT_W'(PORTS - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WRITE  = 2'd1;
   localparam logic [1:0] ST_SELECT = 2'd2;
   localparam logic [1:0] ST_DATA   = 2'd3;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   port_idx_type          port_ff;
   port_idx_type          port_in;
   logic [MAX_PORTS-1:0]  arrive_ff;
   logic [MAX_PORTS-1:0]  tails_ff;
   logic [FLIT_BITS-1:0]  flits_ff [MAX_PORTS];
   logic                  dstop_ff;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic                  send_ff;
   logic                  send_in;
   port_idx_type          src_ff;
   port_idx_type          src_in;
   logic                  locked_ff;
   logic                  locked_in;
   port_idx_type          lock_port_ff;
   port_idx_type          lock_port_in;
   logic [BUF_SIZE_W-1:0] buf_size_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  out_valid_ff;
   logic [FLIT_BITS-1:0]  out_flit_ff;
   logic                  out_tail_ff;
   port_idx_type          out_source_ff;
   logic [MAX_PORTS-1:0]  stop_mask_ff;
   logic                  overflow_ff;

   mpfm_qcmd_type         qcmd;
   logic [MAX_PORTS-1:0]  nonempty;
   logic [CW-1:0]         free_cnt;
   logic [FLIT_BITS:0]    pop_data;

   logic                  req_take;
   logic                  slot_free;
   logic                  finish;
   logic                  pick_valid;
   port_idx_type          pick_port;
   logic                  pop_tail;
   logic [CMP_W-1:0]      free_ext;
   logic [MAX_PORTS-1:0]  lock_onehot;
   logic [MAX_PORTS-1:0]  stop_mask_in;

   mpfm_queues #(
      .PORTS     (PORTS),
      .CAPACITY  (CAPACITY),
      .FLIT_BITS (FLIT_BITS)
   ) u_queues (
      .clock       (clock),
      .reset       (reset),
      .cmd         (qcmd),
      .push_data   ({tails_ff[port_ff], flits_ff[port_ff]}),
      .buffer_size (buf_size_ff),
      .nonempty    (nonempty),
      .free_cnt    (free_cnt),
      .pop_data    (pop_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign finish = (state_ff == ST_DATA) && slot_free;

   // lowest-numbered non-empty queue
   always_comb begin
      pick_valid = 1'b0;
      pick_port = '0;
      for (int p = MAX_PORTS - 1; p >= 0; p--) begin
         if (nonempty[p]) begin
            pick_valid = 1'b1;
            pick_port = PORT_W'(p);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      port_in = port_ff;
      ovf_in = ovf_ff;
      send_in = send_ff;
      src_in = src_ff;
      qcmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_WRITE;
               port_in = '0;
               ovf_in = 1'b0;
            end
         end
         ST_WRITE: begin
            // one arrival per cycle, each seeing the room left by earlier ports
            if (arrive_ff[port_ff]) begin
               if (free_cnt != '0) begin
                  qcmd.push = 1'b1;
                  qcmd.push_port = port_ff;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (port_ff == LAST_PORT) begin
               state_in = ST_SELECT;
            end else begin
               port_in = port_ff + 1'b1;
            end
         end
         ST_SELECT: begin
            send_in = 1'b0;
            src_in = '0;
            if (!dstop_ff) begin
               if (locked_ff) begin
                  if (nonempty[lock_port_ff]) begin
                     send_in = 1'b1;
                     src_in = lock_port_ff;
                  end
               end else if (pick_valid) begin
                  send_in = 1'b1;
                  src_in = pick_port;
               end
            end
            qcmd.pop = send_in;
            qcmd.pop_port = src_in;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // lock follows the sent flit; a single-flit packet does not lock
   assign pop_tail = pop_data[FLIT_BITS];
   always_comb begin
      locked_in = locked_ff;
      lock_port_in = lock_port_ff;
      if (finish && send_ff) begin
         if (locked_ff) begin
            if (pop_tail) begin
               locked_in = 1'b0;
            end
         end else begin
            lock_port_in = src_ff;
            locked_in = !pop_tail;
         end
      end
   end

   assign free_ext = CMP_W'(free_cnt);
   assign lock_onehot = MAX_PORTS'(1) << lock_port_in;
   always_comb begin
      stop_mask_in = '0;
      if (free_ext < LIM_LOW) begin
         stop_mask_in = PORT_ALL;
      end else if (locked_in && free_ext > LIM_LOW && free_ext < LIM_HIGH) begin
         stop_mask_in = PORT_ALL & ~lock_onehot;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         port_ff <= '0;
         ovf_ff <= 1'b0;
         send_ff <= 1'b0;
         src_ff <= '0;
         locked_ff <= 1'b0;
         lock_port_ff <= '0;
         rsp_valid_ff <= 1'b0;
         buf_size_ff <= BUF_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         port_ff <= port_in;
         ovf_ff <= ovf_in;
         send_ff <= send_in;
         src_ff <= src_in;
         locked_ff <= locked_in;
         lock_port_ff <= lock_port_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            buf_size_ff <= csr_ch.buffer_size;
         end
      end
   end

   // transaction payload and result capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         arrive_ff <= req_ch.arrive_mask;
         tails_ff <= req_ch.tail_mask;
         flits_ff[0] <= req_ch.flit_port0;
         flits_ff[1] <= req_ch.flit_port1;
         flits_ff[2] <= req_ch.flit_port2;
         flits_ff[3] <= req_ch.flit_port3;
         dstop_ff <= req_ch.downstream_stop;
      end
      if (finish) begin
         out_valid_ff <= send_ff;
         out_flit_ff <= send_ff ? pop_data[FLIT_BITS-1:0] : '0;
         out_tail_ff <= send_ff && pop_tail;
         out_source_ff <= send_ff ? src_ff : '0;
         stop_mask_ff <= stop_mask_in;
         overflow_ff <= ovf_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_valid = out_valid_ff;
   assign rsp_ch.out_flit = out_flit_ff;
   assign rsp_ch.out_tail = out_tail_ff;
   assign rsp_ch.out_source = out_source_ff;
   assign rsp_ch.stop_mask = stop_mask_ff;
   assign rsp_ch.overflow = overflow_ff;

`ifndef SYNTHESIS
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff &&
      $stable({out_valid_ff, out_flit_ff, out_tail_ff, out_source_ff,
               stop_mask_ff, overflow_ff}))
      else $error("result changed while waiting");

   a_locked_source : assert property (@(posedge clock) disable iff (reset)
      finish && send_ff && locked_ff |-> src_ff == lock_port_ff)
      else $error("locked packet served from another port");

   a_absent_stop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (stop_mask_ff & ~PORT_ALL) == '0)
      else $error("stop raised for a port that does not exist");
`endif

endmodule

`default_nettype wire
